// ===== hw/rtl/bls_pkg.sv =====
`default_nettype none

package bls_pkg;

    // default coordinate width and color word width
    localparam int COORD_BITS_DEF = 10;
    localparam int COLOR_BITS     = 32;

    // depth of the command queue between front and back
    localparam int FIFO_DEPTH_DEF = 4;

    // item kinds carried on the input tuser
    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // control flags of one queued command
    typedef struct packed
    {
        logic is_start;
        logic steep;
        logic minor_down;
    } cmd_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bls_fifo.sv =====
`default_nettype none

module bls_fifo
    import bls_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic      [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    // handshake on both sides
    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = entry_reg[rd_ptr_reg];

    // pointer wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bls_front.sv =====
`default_nettype none

module bls_front
    import bls_pkg::*;
#(
    parameter int  COORD_BITS = COORD_BITS_DEF,
    localparam int CMD_W      = $bits(cmd_flags_t) + 5 * COORD_BITS + COLOR_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  op,
    input  wire logic [COORD_BITS-1:0] start_x,
    input  wire logic [COORD_BITS-1:0] start_y,
    input  wire logic [COORD_BITS-1:0] end_x,
    input  wire logic [COORD_BITS-1:0] end_y,
    input  wire logic [COLOR_BITS-1:0] color,
    output logic                       cmd_valid,
    input  wire logic                  cmd_ready,
    output logic      [CMD_W-1:0]      cmd_data
);

    typedef struct packed
    {
        cmd_flags_t            flags;
        logic [COORD_BITS-1:0] major_pos;
        logic [COORD_BITS-1:0] major_end;
        logic [COORD_BITS-1:0] minor_pos;
        logic [COORD_BITS-1:0] major_delta;
        logic [COORD_BITS-1:0] minor_delta;
        logic [COLOR_BITS-1:0] color;
    } cmd_t;

    logic                  stg_valid_reg;
    logic                  stg_valid_next;
    logic                  stg_start_reg;
    logic [COORD_BITS-1:0] ax_reg;
    logic [COORD_BITS-1:0] ay_reg;
    logic [COORD_BITS-1:0] bx_reg;
    logic [COORD_BITS-1:0] by_reg;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic                  x_gt_reg;
    logic                  x_lt_reg;
    logic                  y_gt_reg;
    logic                  y_lt_reg;
    logic [COLOR_BITS-1:0] color_reg;

    logic                  load;
    logic                  is_start;
    logic                  steep;
    logic                  swap;
    logic                  minor_gt;
    logic                  minor_lt;
    logic [COORD_BITS-1:0] a_maj;
    logic [COORD_BITS-1:0] b_maj;
    logic [COORD_BITS-1:0] a_min;
    logic [COORD_BITS-1:0] b_min;
    cmd_t                  cmd;

    // one stage ahead of the queue
    assign in_ready  = !stg_valid_reg || cmd_ready;
    assign load      = in_valid && in_ready;
    assign cmd_valid = stg_valid_reg;

    // classify the item
    always_comb
    begin
        unique case (op_t'(op))
            OP_START: is_start = 1'b1;
            OP_STEP:  is_start = 1'b0;
            default:  is_start = 1'b0;
        endcase
    end

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (load)
        begin
            stg_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    // endpoint extents and orderings
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stg_start_reg <= is_start;
            ax_reg        <= start_x;
            ay_reg        <= start_y;
            bx_reg        <= end_x;
            by_reg        <= end_y;
            dx_reg        <= (start_x > end_x) ? start_x - end_x : end_x - start_x;
            dy_reg        <= (start_y > end_y) ? start_y - end_y : end_y - start_y;
            x_gt_reg      <= start_x > end_x;
            x_lt_reg      <= end_x > start_x;
            y_gt_reg      <= start_y > end_y;
            y_lt_reg      <= end_y > start_y;
            color_reg     <= color;
        end
    end

    // axis swap for steep lines, then ordering by ascending major axis
    always_comb
    begin
        steep    = dy_reg > dx_reg;
        a_maj    = steep ? ay_reg : ax_reg;
        b_maj    = steep ? by_reg : bx_reg;
        a_min    = steep ? ax_reg : ay_reg;
        b_min    = steep ? bx_reg : by_reg;
        swap     = steep ? y_gt_reg : x_gt_reg;
        minor_gt = steep ? x_gt_reg : y_gt_reg;
        minor_lt = steep ? x_lt_reg : y_lt_reg;

        cmd.flags.is_start   = stg_start_reg;
        cmd.flags.steep      = steep;
        cmd.flags.minor_down = swap ? minor_lt : minor_gt;
        cmd.major_pos        = swap ? b_maj : a_maj;
        cmd.major_end        = swap ? a_maj : b_maj;
        cmd.minor_pos        = swap ? b_min : a_min;
        cmd.major_delta      = steep ? dy_reg : dx_reg;
        cmd.minor_delta      = steep ? dx_reg : dy_reg;
        cmd.color            = color_reg;
    end

    assign cmd_data = cmd;

endmodule

`default_nettype wire

// ===== hw/rtl/bls_back.sv =====
`default_nettype none

module bls_back
    import bls_pkg::*;
#(
    parameter int  COORD_BITS = COORD_BITS_DEF,
    localparam int CMD_W      = $bits(cmd_flags_t) + 5 * COORD_BITS + COLOR_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire logic [CMD_W-1:0]      cmd_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [COORD_BITS-1:0] pixel_x,
    output logic      [COORD_BITS-1:0] pixel_y,
    output logic      [COLOR_BITS-1:0] pixel_color,
    output logic                       last
);

    localparam int ERR_W = COORD_BITS + 3;

    typedef struct packed
    {
        cmd_flags_t            flags;
        logic [COORD_BITS-1:0] major_pos;
        logic [COORD_BITS-1:0] major_end;
        logic [COORD_BITS-1:0] minor_pos;
        logic [COORD_BITS-1:0] major_delta;
        logic [COORD_BITS-1:0] minor_delta;
        logic [COLOR_BITS-1:0] color;
    } cmd_t;

    cmd_t                     cmd;
    logic                     take;
    logic                     step_fire;
    logic                     is_last;
    logic                     minor_move;
    logic signed [ERR_W-1:0]  delta_s;
    logic signed [ERR_W-1:0]  incr_s;

    logic                     active_reg;
    logic                     active_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     steep_reg;
    logic                     minor_down_reg;
    logic [COORD_BITS-1:0]    major_pos_reg;
    logic [COORD_BITS-1:0]    major_end_reg;
    logic [COORD_BITS-1:0]    minor_pos_reg;
    logic signed [ERR_W-1:0]  error_acc_reg;
    logic signed [ERR_W-1:0]  err_incr_reg;
    logic signed [ERR_W-1:0]  err_thresh_reg;
    logic signed [ERR_W-1:0]  err_adjust_reg;
    logic [COLOR_BITS-1:0]    line_color_reg;
    logic [COORD_BITS-1:0]    pixel_x_reg;
    logic [COORD_BITS-1:0]    pixel_y_reg;
    logic [COLOR_BITS-1:0]    pixel_color_reg;
    logic                     last_reg;

    assign cmd = cmd_t'(cmd_data);

    // a start never needs the output slot, a step needs it free or draining
    assign cmd_ready = cmd.flags.is_start || !out_valid_reg || out_ready;
    assign take      = cmd_valid && cmd_ready;
    assign step_fire = take && !cmd.flags.is_start && active_reg;
    assign is_last   = (major_pos_reg == major_end_reg);

    // minor step decided against a threshold set up at line start
    assign minor_move = (error_acc_reg > err_thresh_reg);
    assign delta_s    = $signed({3'b000, cmd.major_delta});
    assign incr_s     = $signed({2'b00, cmd.minor_delta, 1'b0});

    // control next state
    always_comb
    begin
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take && cmd.flags.is_start)
        begin
            active_next = 1'b1;
        end
        else if (step_fire)
        begin
            out_valid_next = 1'b1;
            if (is_last)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // line state: load on start, advance on each step
    always_ff @(posedge clk)
    begin
        if (take && cmd.flags.is_start)
        begin
            steep_reg      <= cmd.flags.steep;
            minor_down_reg <= cmd.flags.minor_down;
            major_pos_reg  <= cmd.major_pos;
            major_end_reg  <= cmd.major_end;
            minor_pos_reg  <= cmd.minor_pos;
            error_acc_reg  <= '0;
            err_incr_reg   <= incr_s;
            err_thresh_reg <= delta_s - incr_s;
            err_adjust_reg <= incr_s - (delta_s <<< 1);
            line_color_reg <= cmd.color;
        end
        else if (step_fire && !is_last)
        begin
            major_pos_reg <= major_pos_reg + 1'b1;
            if (minor_move)
            begin
                minor_pos_reg <= minor_down_reg ? minor_pos_reg - 1'b1
                                                : minor_pos_reg + 1'b1;
                error_acc_reg <= error_acc_reg + err_adjust_reg;
            end
            else
            begin
                error_acc_reg <= error_acc_reg + err_incr_reg;
            end
        end
    end

    // output register, screen order restored
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            pixel_x_reg     <= steep_reg ? minor_pos_reg : major_pos_reg;
            pixel_y_reg     <= steep_reg ? major_pos_reg : minor_pos_reg;
            pixel_color_reg <= line_color_reg;
            last_reg        <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bresenham_line_stepper_core.sv =====
// path: a step passes the front stage register, the command queue, the output register
// throughput: one item per cycle unless stalled; the back end emits one pixel per cycle
// through its error accumulator loop while the master side accepts; a start emits none
// a stalled master side fills the command queue before the slave side stalls
// reset: asynchronous active low, clears the queue, the active line and the output slot
`default_nettype none

module bresenham_line_stepper_core
    import bls_pkg::*;
#(
    parameter int  COORD_BITS = COORD_BITS_DEF,
    parameter int  FIFO_DEPTH = FIFO_DEPTH_DEF,
    localparam int IN_BITS    = 4 * COORD_BITS + COLOR_BITS,
    localparam int OUT_BITS   = 2 * COORD_BITS + COLOR_BITS,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8,
    localparam int CMD_W      = $bits(cmd_flags_t) + 5 * COORD_BITS + COLOR_BITS
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // start_x, start_y, end_x, end_y, color, zero fill
    input  wire logic [IN_W-1:0]  s_tdata,
    // op
    input  wire logic             s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // pixel_x, pixel_y, pixel_color, zero fill
    output logic      [OUT_W-1:0] m_tdata,
    output logic                  m_tlast
);

    logic                  cmd_in_valid;
    logic                  cmd_in_ready;
    logic [CMD_W-1:0]      cmd_in_data;
    logic                  cmd_out_valid;
    logic                  cmd_out_ready;
    logic [CMD_W-1:0]      cmd_out_data;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;

    // accept and set up
    bls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .op        (s_tuser),
        .start_x   (s_tdata[COORD_BITS-1:0]),
        .start_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .end_x     (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .end_y     (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .color     (s_tdata[IN_BITS-1:4*COORD_BITS]),
        .cmd_valid (cmd_in_valid),
        .cmd_ready (cmd_in_ready),
        .cmd_data  (cmd_in_data)
    );

    // command queue
    bls_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cmd_in_valid),
        .wr_ready (cmd_in_ready),
        .wr_data  (cmd_in_data),
        .rd_valid (cmd_out_valid),
        .rd_ready (cmd_out_ready),
        .rd_data  (cmd_out_data)
    );

    // line stepping
    bls_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_out_valid),
        .cmd_ready   (cmd_out_ready),
        .cmd_data    (cmd_out_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last        (m_tlast)
    );

    // pack the pixel transaction
    assign m_tdata = OUT_W'({pixel_color, pixel_y, pixel_x});

endmodule

`default_nettype wire
